/* sv/bce_pkg.sv */
// Shared types and constants for the cascaded biquad equalizer.
// Item structs, operation codes, coefficient slots, word widths.
// No dependencies.
package bce_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 21;
	localparam int NUM_SLOTS      = 5;
	localparam int BAND_IDX_BITS  = 3;
	localparam int SLOT_BITS      = 3;
	localparam int PROD_W         = 2 * SAMPLE_BITS;
	localparam int ACC_W          = PROD_W + 3;   // five products summed

	// 1.0 in Q2.21, or the largest word when 1.0 does not fit
	localparam logic [SAMPLE_BITS-1:0] COEF_ONE = (COEF_FRAC_BITS < SAMPLE_BITS - 1) ?
		(SAMPLE_BITS'(1) << COEF_FRAC_BITS) : {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

	typedef enum logic [1:0] {
		OP_FILTER = 2'd0,
		OP_COEF   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	localparam logic [SLOT_BITS-1:0] SLOT_B0 = 3'd0;
	localparam logic [SLOT_BITS-1:0] SLOT_B1 = 3'd1;
	localparam logic [SLOT_BITS-1:0] SLOT_B2 = 3'd2;
	localparam logic [SLOT_BITS-1:0] SLOT_A1 = 3'd3;
	localparam logic [SLOT_BITS-1:0] SLOT_A2 = 3'd4;
	localparam logic [SLOT_BITS-1:0] SLOT_FIN = 3'd5;   // sequencer step after the MACs

	typedef struct packed {
		logic [1:0]                    operation;
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          block_end;
		logic [BAND_IDX_BITS-1:0]      band_index;
		logic [SLOT_BITS-1:0]          coef_slot;
		logic signed [SAMPLE_BITS-1:0] coef_value;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic                          block_end_out;
		logic                          clipped;
	} out_item_t;

	// sample moving down the chain
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x;
		logic                          clip;
	} tok_t;

	// coefficient write into one section
	typedef struct packed {
		logic                          we;
		logic [SLOT_BITS-1:0]          slot;
		logic signed [SAMPLE_BITS-1:0] value;
	} coef_wr_t;

endpackage

/* sv/biquad_cascade_equalizer_core.sv */
// Top level of the cascaded direct-form-I biquad equalizer.
// Depends on bce_pkg and bce_cell.
//
// Usage:
//  - in_valid/in_ready carry one in_item_t. Operation filter runs the sample
//    through the section chain and yields one out_item_t on out_valid/out_ready.
//    Coefficient write, history clear and no-op take effect at acceptance and
//    give no result; in_ready stays high after them.
//  - A filter item runs five MAC steps on each active section's one multiplier,
//    then round/saturate; unused sections forward it untouched. The result
//    then passes the holding stage into the output register. One filter
//    item is in the chain at a time and in_ready returns as its result enters
//    the output register.
//  - A finished result moves to the output register; the next item is taken
//    while it waits there. If the receiver still stalls when the chain finishes
//    again, the result waits in a holding stage and in_ready stays low.
//  - cfg_we/cfg_wdata write active_bands (values above NUM_BANDS act as
//    NUM_BANDS); write only while the block is idle.
//  - Reset clears all history, sets every section to passthrough (b0 = 1.0)
//    and active_bands to zero.
module biquad_cascade_equalizer_core
	import bce_pkg::*;
#(
	parameter int NUM_BANDS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item,
	input  logic      cfg_we,
	input  logic [3:0] cfg_wdata
);

	logic [3:0] act_q;
	logic       busy_q;
	logic       be_q;
	logic       done_vld_q;
	tok_t       done_tok_q;
	logic       out_vld_q;
	out_item_t  out_item_q;

	logic       acc_item;
	logic       launch;
	logic       clr;
	logic       done_move;

	logic       cell_vld [NUM_BANDS+1];
	tok_t       cell_tok [NUM_BANDS+1];

	assign in_ready  = !busy_q;
	assign acc_item  = in_valid && in_ready;
	assign launch    = acc_item && (in_item.operation == OP_FILTER);
	assign clr       = acc_item && (in_item.operation == OP_CLEAR);
	assign done_move = done_vld_q && (!out_vld_q || out_ready);

	// chain head
	assign cell_vld[0]      = launch;
	assign cell_tok[0].x    = in_item.sample_in;
	assign cell_tok[0].clip = 1'b0;

	for (genvar b = 0; b < NUM_BANDS; b++) begin : g_cell
		coef_wr_t cwr;
		logic     sel;
		logic     active;

		// band_index only reaches the first sections its width covers
		assign sel = (b < (1 << BAND_IDX_BITS)) &&
			(in_item.band_index == BAND_IDX_BITS'(b));
		assign cwr.we    = acc_item && (in_item.operation == OP_COEF) && sel;
		assign cwr.slot  = in_item.coef_slot;
		assign cwr.value = in_item.coef_value;
		assign active    = int'(act_q) > b;

		bce_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.active  (active),
			.clr     (clr),
			.cwr     (cwr),
			.in_vld  (cell_vld[b]),
			.in_tok  (cell_tok[b]),
			.out_vld (cell_vld[b+1]),
			.out_tok (cell_tok[b+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q      <= '0;
			busy_q     <= 1'b0;
			done_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				act_q <= cfg_wdata;
			end
			if (launch) begin
				busy_q <= 1'b1;
			end
			if (cell_vld[NUM_BANDS]) begin
				done_vld_q <= 1'b1;
			end
			if (done_move) begin
				done_vld_q <= 1'b0;
				busy_q     <= 1'b0;
				out_vld_q  <= 1'b1;
			end else if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			be_q <= in_item.block_end;
		end
		if (cell_vld[NUM_BANDS]) begin
			done_tok_q <= cell_tok[NUM_BANDS];
		end
		if (done_move) begin
			out_item_q.sample_out    <= done_tok_q.x;
			out_item_q.clipped       <= done_tok_q.clip;
			out_item_q.block_end_out <= be_q;
		end
	end

	assign out_valid = out_vld_q;
	assign out_item  = out_item_q;

endmodule

/* sv/bce_cell.sv */
// One biquad section of the equalizer chain: coefficients, history, one shared MAC.
// Depends on bce_pkg.
module bce_cell
	import bce_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     active,
	input  logic     clr,
	input  coef_wr_t cwr,
	input  logic     in_vld,
	input  tok_t     in_tok,
	output logic     out_vld,
	output tok_t     out_tok
);

	logic signed [SAMPLE_BITS-1:0] coef_q [NUM_SLOTS];
	logic signed [SAMPLE_BITS-1:0] x1_q, x2_q, y1_q, y2_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          clip_q;
	logic                          busy_q;
	logic [SLOT_BITS-1:0]          step_q;
	logic signed [PROD_W-1:0]      prod_s1;
	logic                          sub_s1;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          out_vld_q;
	tok_t                          out_tok_q;

	logic signed [SAMPLE_BITS-1:0] coef_sel, opnd_sel;
	logic signed [ACC_W-1:0]       prod_ext, acc_nxt, y_full;
	logic [ACC_W-SAMPLE_BITS:0]    y_hi;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic                          y_clip;

	always_comb begin
		case (step_q)
			SLOT_B0: begin coef_sel = coef_q[0]; opnd_sel = x_q;  end
			SLOT_B1: begin coef_sel = coef_q[1]; opnd_sel = x1_q; end
			SLOT_B2: begin coef_sel = coef_q[2]; opnd_sel = x2_q; end
			SLOT_A1: begin coef_sel = coef_q[3]; opnd_sel = y1_q; end
			SLOT_A2: begin coef_sel = coef_q[4]; opnd_sel = y2_q; end
			default: begin coef_sel = '0;        opnd_sel = '0;   end
		endcase
	end

	// feedback terms are subtracted
	assign prod_ext = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign acc_nxt  = sub_s1 ? acc_q - prod_ext : acc_q + prod_ext;
	assign y_full   = acc_nxt >>> COEF_FRAC_BITS;
	assign y_hi     = y_full[ACC_W-1:SAMPLE_BITS-1];
	assign y_clip   = !((&y_hi) || !(|y_hi));

	always_comb begin
		if (!y_clip) begin
			y_sat = y_full[SAMPLE_BITS-1:0];
		end else if (y_full[ACC_W-1]) begin
			y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				coef_q[s] <= (s == 0) ? COEF_ONE : '0;
			end
			x1_q      <= '0;
			x2_q      <= '0;
			y1_q      <= '0;
			y2_q      <= '0;
			busy_q    <= 1'b0;
			step_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= 1'b0;
			if (cwr.we) begin
				case (cwr.slot)
					SLOT_B0: coef_q[0] <= cwr.value;
					SLOT_B1: coef_q[1] <= cwr.value;
					SLOT_B2: coef_q[2] <= cwr.value;
					SLOT_A1: coef_q[3] <= cwr.value;
					SLOT_A2: coef_q[4] <= cwr.value;
					default: ;
				endcase
			end
			if (clr) begin
				x1_q <= '0;
				x2_q <= '0;
				y1_q <= '0;
				y2_q <= '0;
			end
			if (in_vld && active) begin
				busy_q <= 1'b1;
				step_q <= SLOT_B0;
			end else if (in_vld) begin
				out_vld_q <= 1'b1;   // unused section: forward untouched
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == SLOT_FIN) begin
					busy_q    <= 1'b0;
					out_vld_q <= 1'b1;
					x2_q      <= x1_q;
					x1_q      <= x_q;
					y2_q      <= y1_q;
					y1_q      <= y_sat;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (in_vld) begin
			x_q    <= in_tok.x;
			clip_q <= in_tok.clip;
			acc_q  <= ROUND_HALF;
			if (!active) begin
				out_tok_q <= in_tok;
			end
		end else if (busy_q) begin
			prod_s1 <= PROD_W'(coef_sel) * PROD_W'(opnd_sel);
			sub_s1  <= (step_q == SLOT_A1) || (step_q == SLOT_A2);
			if (step_q != SLOT_B0) begin
				acc_q <= acc_nxt;
			end
			if (step_q == SLOT_FIN) begin
				out_tok_q.x    <= y_sat;
				out_tok_q.clip <= clip_q | y_clip;
			end
		end
	end

	assign out_vld = out_vld_q;
	assign out_tok = out_tok_q;

endmodule

/* sv/bce_chk.sv */
// Port-level checks for the cascaded biquad equalizer, bound to its top level.
// Depends on bce_pkg and biquad_cascade_equalizer_core.
module bce_chk
	import bce_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed or dropped under stall");

	// a filter item occupies the chain
	a_filter_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_item.operation == OP_FILTER) |=> !in_ready)
		else $error("input taken while a sample is in the chain");

	// control items finish at acceptance
	a_ctrl_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_item.operation != OP_FILTER) |=> in_ready)
		else $error("control item blocked the input");

	// a new result only comes from a sample in flight
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a sample in the chain");

endmodule

bind biquad_cascade_equalizer_core bce_chk u_bce_chk (.*);
